FILE: src/rsi_pkg.sv
// rsi_pkg: shared constants and the divider request type for the rsi core
// used by rsi_divider and relative_strength_index_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

	localparam int DEF_PRICE_BITS    = 24;
	localparam int DEF_FRACTION_BITS = 8;

	localparam int AVG_W    = 32;
	localparam int REM_W    = 33;
	localparam int STEP_W   = 6;
	localparam int PERIOD_W = 8;
	localparam int RSI_W    = 14;
	localparam int MUL_B_W  = 14;
	localparam int PROD_W   = AVG_W + MUL_B_W;
	localparam int NUM_W    = PROD_W + 1;

	localparam logic [STEP_W-1:0]   WIDE_STEPS   = STEP_W'(AVG_W);
	localparam logic [STEP_W-1:0]   RSI_STEPS    = STEP_W'(RSI_W);
	localparam logic [MUL_B_W-1:0]  RSI_SCALE    = MUL_B_W'(10000);
	localparam logic [RSI_W-1:0]    RSI_FLAT     = RSI_W'(5000);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
	localparam logic [PERIOD_W-1:0] SMOOTH_MARK  = '1;

	typedef struct packed {
		logic [REM_W-1:0]  rem_init;
		logic [AVG_W-1:0]  low;
		logic [REM_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

`default_nettype wire

FILE: src/relative_strength_index_core.sv
// relative_strength_index_core: wilder rsi over a stream of closing prices
// flow: a reference-only price and each warm-up change but the last go back to idle; a result
//   price takes two 32-step passes of the shared divider (gain and loss averages) and one 14-step
//   pass for the rsi, skipped when flat (rsi 5000), then waits for the output register to be free
// throughput: one price in flight, in_ready low until it is done (a result price: result loaded)
// reset: period 14, no reference held, averages and warm-up count cleared; depends on rsi_pkg, rsi_divider
`timescale 1ns / 1ps
`default_nettype none

module relative_strength_index_core
	import rsi_pkg::*;
#(
	parameter int PRICE_BITS    = DEF_PRICE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [PERIOD_W-1:0]   period,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PRICE_BITS-1:0] close_price,
	input  wire logic                  starts_series,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [RSI_W-1:0]           rsi_value
);

	localparam int SCL_W = PRICE_BITS + FRACTION_BITS;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHG    = 4'd1;
	localparam logic [3:0] ST_SUM    = 4'd2;
	localparam logic [3:0] ST_MUL_G  = 4'd3;
	localparam logic [3:0] ST_DIV_G  = 4'd4;
	localparam logic [3:0] ST_WAIT_G = 4'd5;
	localparam logic [3:0] ST_MUL_L  = 4'd6;
	localparam logic [3:0] ST_DIV_L  = 4'd7;
	localparam logic [3:0] ST_WAIT_L = 4'd8;
	localparam logic [3:0] ST_MUL_R  = 4'd9;
	localparam logic [3:0] ST_DIV_R  = 4'd10;
	localparam logic [3:0] ST_WAIT_R = 4'd11;
	localparam logic [3:0] ST_EMIT   = 4'd12;

	logic [3:0]            state_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [PRICE_BITS-1:0] price_q;
	logic                  start_q;
	logic [PRICE_BITS-1:0] prev_q;
	logic                  have_ref_q;
	logic [AVG_W-1:0]      avg_gain_q;
	logic [AVG_W-1:0]      avg_loss_q;
	logic [PERIOD_W-1:0]   cnt_q;
	logic                  warm_q;
	logic [AVG_W-1:0]      gain_q;
	logic [AVG_W-1:0]      loss_q;
	logic [PROD_W-1:0]     prod_q;
	logic [AVG_W-1:0]      add_q;
	logic [REM_W-1:0]      total_q;
	logic [RSI_W-1:0]      res_q;
	logic                  out_valid_q;
	logic [RSI_W-1:0]      rsi_value_q;

	logic [PERIOD_W-1:0]   n_eff;
	logic [PRICE_BITS-1:0] diff;
	logic [SCL_W-1:0]      scaled;
	logic [AVG_W-1:0]      scaled_sat;
	logic [AVG_W:0]        sum_g;
	logic [AVG_W:0]        sum_l;
	logic [AVG_W-1:0]      sum_g_sat;
	logic [AVG_W-1:0]      sum_l_sat;
	logic [PERIOD_W-1:0]   cnt_nxt;
	logic [AVG_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [PROD_W-1:0]     product;
	logic [NUM_W-1:0]      num;
	logic                  div_start;
	div_req_t              div_req;
	logic                  div_done;
	logic [AVG_W-1:0]      div_quot;
	logic                  emit_load;

	assign n_eff = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;

	// price change, scaled to the average format with saturation
	assign diff       = (price_q >= prev_q) ? (price_q - prev_q) : (prev_q - price_q);
	assign scaled     = SCL_W'(diff) << FRACTION_BITS;
	assign scaled_sat = ((scaled >> AVG_W) != '0) ? '1 : AVG_W'(scaled);

	assign sum_g     = {1'b0, avg_gain_q} + {1'b0, gain_q};
	assign sum_l     = {1'b0, avg_loss_q} + {1'b0, loss_q};
	assign sum_g_sat = sum_g[AVG_W] ? '1 : sum_g[AVG_W-1:0];
	assign sum_l_sat = sum_l[AVG_W] ? '1 : sum_l[AVG_W-1:0];
	assign cnt_nxt   = cnt_q + PERIOD_W'(1);

	// shared multiplier: avg*(n-1), or avg*0 at the end of warm-up, or gain*10000
	always_comb begin
		mul_a = avg_gain_q;
		mul_b = MUL_B_W'(n_eff - PERIOD_W'(1));
		case (state_q)
			ST_MUL_L: begin
				mul_a = avg_loss_q;
				mul_b = warm_q ? '0 : MUL_B_W'(n_eff - PERIOD_W'(1));
			end
			ST_MUL_R: begin
				mul_b = RSI_SCALE;
			end
			default: begin
				mul_b = warm_q ? '0 : MUL_B_W'(n_eff - PERIOD_W'(1));
			end
		endcase
	end

	assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign num     = NUM_W'(prod_q) + NUM_W'(add_q);

	always_comb begin
		div_req.rem_init = REM_W'(num[NUM_W-1:AVG_W]);
		div_req.low      = num[AVG_W-1:0];
		div_req.divisor  = REM_W'(n_eff);
		div_req.steps    = WIDE_STEPS;
		if (state_q == ST_DIV_R) begin
			div_req.rem_init = num[NUM_W-1:RSI_W];
			div_req.low      = AVG_W'(num[RSI_W-1:0]) << (AVG_W - RSI_W);
			div_req.divisor  = total_q;
			div_req.steps    = RSI_STEPS;
		end
	end

	assign div_start = (state_q == ST_DIV_G) || (state_q == ST_DIV_L) ||
		((state_q == ST_DIV_R) && (total_q != '0));

	rsi_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PERIOD_RESET;
			have_ref_q  <= 1'b0;
			cnt_q       <= '0;
			warm_q      <= 1'b0;
			avg_gain_q  <= '0;
			avg_loss_q  <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= period;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHG;
					end
				end
				ST_CHG: begin
					prev_q <= price_q;
					if (start_q || !have_ref_q) begin
						have_ref_q <= 1'b1;
						avg_gain_q <= '0;
						avg_loss_q <= '0;
						cnt_q      <= '0;
						state_q    <= ST_IDLE;
					end else if (cnt_q != SMOOTH_MARK) begin
						state_q <= ST_SUM;
					end else begin
						warm_q  <= 1'b0;
						state_q <= ST_MUL_G;
					end
				end
				ST_SUM: begin
					avg_gain_q <= sum_g_sat;
					avg_loss_q <= sum_l_sat;
					if (cnt_nxt < n_eff) begin
						cnt_q   <= cnt_nxt;
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= SMOOTH_MARK;
						warm_q  <= 1'b1;
						state_q <= ST_MUL_G;
					end
				end
				ST_MUL_G:  state_q <= ST_DIV_G;
				ST_DIV_G:  state_q <= ST_WAIT_G;
				ST_WAIT_G: begin
					if (div_done) begin
						avg_gain_q <= div_quot;
						state_q    <= ST_MUL_L;
					end
				end
				ST_MUL_L:  state_q <= ST_DIV_L;
				ST_DIV_L:  state_q <= ST_WAIT_L;
				ST_WAIT_L: begin
					if (div_done) begin
						avg_loss_q <= div_quot;
						state_q    <= ST_MUL_R;
					end
				end
				ST_MUL_R:  state_q <= ST_DIV_R;
				ST_DIV_R: begin
					if (total_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_WAIT_R;
					end
				end
				ST_WAIT_R: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			price_q <= close_price;
			start_q <= starts_series;
		end
		if (state_q == ST_CHG) begin
			gain_q <= (price_q >= prev_q) ? scaled_sat : '0;
			loss_q <= (price_q >= prev_q) ? '0 : scaled_sat;
		end
		case (state_q)
			ST_MUL_G: begin
				prod_q <= product;
				add_q  <= warm_q ? avg_gain_q : gain_q;
			end
			ST_MUL_L: begin
				prod_q <= product;
				add_q  <= warm_q ? avg_loss_q : loss_q;
			end
			ST_MUL_R: begin
				prod_q  <= product;
				add_q   <= AVG_W'(({1'b0, avg_gain_q} + {1'b0, avg_loss_q}) >> 1);
				total_q <= {1'b0, avg_gain_q} + {1'b0, avg_loss_q};
			end
			default: begin
			end
		endcase
		if (state_q == ST_DIV_R && total_q == '0) begin
			res_q <= RSI_FLAT;
		end else if (state_q == ST_WAIT_R && div_done) begin
			res_q <= div_quot[RSI_W-1:0];
		end
		if (emit_load) begin
			rsi_value_q <= res_q;
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign rsi_value = rsi_value_q;

endmodule

`default_nettype wire

FILE: src/rsi_divider.sv
// rsi_divider: restoring divider, one quotient bit per cycle
// depends on rsi_pkg (div_req_t and widths)
`timescale 1ns / 1ps
`default_nettype none

module rsi_divider
	import rsi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire div_req_t         req,
	output logic                  done,
	output logic [AVG_W-1:0]      quotient
);

	logic [REM_W-1:0]  rem_q;
	logic [AVG_W-1:0]  low_q;
	logic [REM_W-1:0]  div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W:0]    shifted;
	logic              take;

	assign shifted = {rem_q, low_q[AVG_W-1]};
	assign take    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= req.rem_init;
			low_q <= req.low;
			div_q <= req.divisor;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= REM_W'(shifted - {1'b0, div_q});
			end else begin
				rem_q <= shifted[REM_W-1:0];
			end
			low_q <= {low_q[AVG_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

`default_nettype wire

FILE: tb/rsi_checker.sv
`timescale 1ns / 1ps
// rsi_checker: watches the period, price and rsi channels of the rsi core,
// keeps its own wilder rsi model and compares every rsi request in order
// depends on rsi_pkg
module rsi_checker
	import rsi_pkg::*;
#(
	parameter int PRICE_BITS    = DEF_PRICE_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [PERIOD_W-1:0]   period,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [PRICE_BITS-1:0] close_price,
	input  logic                  starts_series,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [RSI_W-1:0]      rsi_value,
	output int                    mismatch_count,
	output int                    pending_count,
	output int                    checked_count
);

	logic [PERIOD_W-1:0]   period_reg;
	logic [PRICE_BITS-1:0] last_close;
	logic                  ref_held;
	logic [AVG_W-1:0]      gain_avg;
	logic [AVG_W-1:0]      loss_avg;
	logic [PERIOD_W-1:0]   warm_count;
	logic [RSI_W-1:0]      rsi_expected[$];

	function automatic logic [AVG_W-1:0] clip32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[AVG_W-1:0];
	endfunction

	function automatic logic [AVG_W-1:0] wilder_step(input logic [AVG_W-1:0] avg,
			input logic [AVG_W-1:0] x, input logic [PERIOD_W-1:0] n);
		logic [63:0] acc;
		acc = 64'(avg) * (64'(n) - 64'd1) + 64'(x);
		return clip32(acc / 64'(n));
	endfunction

	function automatic logic [RSI_W-1:0] rsi_of_averages(input logic [AVG_W-1:0] g,
			input logic [AVG_W-1:0] l);
		logic [63:0] total;
		total = 64'(g) + 64'(l);
		if (total == 64'd0)
			return RSI_FLAT;
		return RSI_W'((64'(g) * 64'(RSI_SCALE) + total / 64'd2) / total);
	endfunction

	task automatic advance_price(input logic [PRICE_BITS-1:0] price, input logic start);
		logic [PERIOD_W-1:0] n;
		logic [AVG_W-1:0]    gain;
		logic [AVG_W-1:0]    loss;
		n    = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
		gain = '0;
		loss = '0;
		if (start || !ref_held) begin
			last_close = price;
			ref_held   = 1'b1;
			gain_avg   = '0;
			loss_avg   = '0;
			warm_count = '0;
			return;
		end
		if (price >= last_close)
			gain = clip32(64'(price - last_close) << FRACTION_BITS);
		else
			loss = clip32(64'(last_close - price) << FRACTION_BITS);
		last_close = price;
		if (warm_count != SMOOTH_MARK) begin
			gain_avg   = clip32(64'(gain_avg) + 64'(gain));
			loss_avg   = clip32(64'(loss_avg) + 64'(loss));
			warm_count = warm_count + 1'b1;
			if (warm_count < n)
				return;
			gain_avg   = gain_avg / AVG_W'(n);
			loss_avg   = loss_avg / AVG_W'(n);
			warm_count = SMOOTH_MARK;
		end else begin
			gain_avg = wilder_step(gain_avg, gain, n);
			loss_avg = wilder_step(loss_avg, loss, n);
		end
		rsi_expected.insert(rsi_expected.size(), rsi_of_averages(gain_avg, loss_avg));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_reg = PERIOD_RESET;
			last_close = '0;
			ref_held   = 1'b0;
			gain_avg   = '0;
			loss_avg   = '0;
			warm_count = '0;
			rsi_expected.delete();
			mismatch_count = 0;
			checked_count  = 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				period_reg = period;
			if (out_valid && out_ready) begin
				if (rsi_expected.size() == 0) begin
					$error("rsi_value: unexpected request, actual %0d", rsi_value);
					mismatch_count++;
				end else begin
					if (rsi_value !== rsi_expected[0]) begin
						$error("rsi_value: expected %0d, actual %0d", rsi_expected[0],
							rsi_value);
						mismatch_count++;
					end
					void'(rsi_expected.pop_front());
					checked_count++;
				end
			end
			if (in_valid && in_ready)
				advance_price(close_price, starts_series);
			pending_count <= rsi_expected.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives prices and period settings into relative_strength_index_core
// under random stalls, none after the first 1200 prices; rsi_checker predicts and compares; uses rsi_pkg
module tb_top;
	import rsi_pkg::*;

	localparam int PRICE_W      = DEF_PRICE_BITS;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES       = 10;
	localparam int PICK_RANDOM  = 256;
	localparam int DIRECTED_N   = 21;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] period        = '0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic [PRICE_W-1:0]  close_price   = '0;
	logic                starts_series = 1'b0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic [RSI_W-1:0]    rsi_value;

	int mismatch_count;
	int pending_count;
	int checked_count;
	int tx_idle_pct  = 21;
	int rx_idle_pct  = 57;
	int prices_sent  = 0;
	int period_writes = 0;
	int cycle_count  = 0;

	int unsigned dir_price[DIRECTED_N] = '{0, 24'hFF_FFFF, 0, 24'hFF_FFFF, 0,
		5, 5, 5, 5, 5, 100, 200, 300, 400, 500, 1000, 900, 800, 700, 123456, 123000};
	bit dir_start[DIRECTED_N] = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0,
		1, 0, 0, 0, 1, 0};
	int phase_period[PHASES] = '{2, 255, 0, 1, 14, 3, 128, PICK_RANDOM, PICK_RANDOM,
		PICK_RANDOM};
	int phase_items[PHASES] = '{150, 520, 100, 100, 200, 150, 200, 130, 130, 120};

	relative_strength_index_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.period       (period),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.close_price  (close_price),
		.starts_series(starts_series),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rsi_value    (rsi_value)
	);

	rsi_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.period        (period),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.close_price   (close_price),
		.starts_series (starts_series),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rsi_value     (rsi_value),
		.mismatch_count(mismatch_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles", cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic write_period(input logic [PERIOD_W-1:0] v);
		cfg_valid <= 1'b1;
		period    <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		period_writes++;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_price(input logic [PRICE_W-1:0] price, input logic start);
		if (prices_sent < 600) begin
			tx_idle_pct = 21;
			rx_idle_pct = 57;
		end else if (prices_sent < 1200) begin
			tx_idle_pct = 57;
			rx_idle_pct = 21;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		close_price   <= price;
		starts_series <= start;
		do @(posedge clk); while (!in_ready);
		prices_sent++;
	endtask

	function automatic logic [PRICE_W-1:0] next_close(input logic [PRICE_W-1:0] last);
		int unsigned pick;
		longint      step_v;
		longint      target;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return last;
		if (pick < 75)
			step_v = $urandom_range(0, 2000);
		else if (pick < 85)
			step_v = $urandom_range(0, 1 << 20);
		else if (pick < 95)
			return PRICE_W'($urandom());
		else
			return $urandom_range(0, 1) ? {PRICE_W{1'b1}} : {PRICE_W{1'b0}};
		target = $urandom_range(0, 1) ? longint'(last) + step_v : longint'(last) - step_v;
		if (target < 0)
			target = 0;
		if (target > (longint'(1) << PRICE_W) - 1)
			target = (longint'(1) << PRICE_W) - 1;
		return PRICE_W'(target);
	endfunction

	initial begin
		logic [PRICE_W-1:0] price;
		int                 p;
		int                 start_pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, saturating sums, flat, all-gain, all-loss, restarts
		write_period(PERIOD_W'(3));
		for (int i = 0; i < DIRECTED_N; i++)
			send_price(PRICE_W'(dir_price[i]), dir_start[i]);
		price = PRICE_W'(dir_price[DIRECTED_N-1]);
		in_valid <= 1'b0;
		wait_idle();

		// period changes land mid warm-up and mid smoothing as the phases go
		for (int ph = 0; ph < PHASES; ph++) begin
			p = (phase_period[ph] == PICK_RANDOM) ? $urandom_range(0, 255) : phase_period[ph];
			write_period(PERIOD_W'(p));
			start_pct = (p >= 100) ? 0 : 3;
			for (int i = 0; i < phase_items[ph]; i++) begin
				price = next_close(price);
				send_price(price, (i == 0 && ph % 2 == 1) ||
					($urandom_range(0, 99) < start_pct));
			end
			in_valid <= 1'b0;
			wait_idle();
		end

		$display("run covered %0d prices across %0d period settings", prices_sent,
			period_writes);
		$display("%0d rsi requests checked", checked_count);
		if (pending_count != 0)
			$error("rsi_value: %0d expected requests never arrived", pending_count);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
